// ===== hdl/ao_pkg.sv =====
`default_nettype none
package ao_pkg;
  localparam int unsigned PW = 24;
  localparam int unsigned AW = 17;
  localparam int unsigned MW = 32;
  localparam int unsigned SW = 48;

  localparam logic [0:0] CFG_ALPHA_MAIN   = 1'b0;
  localparam logic [0:0] CFG_ALPHA_SIGNAL = 1'b1;

  // one-hot sequencer states
  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_SQ    = 11'b00000000010,
    ST_ENV   = 11'b00000000100,
    ST_MSQ   = 11'b00000001000,
    ST_ROOT  = 11'b00000010000,
    ST_SIG   = 11'b00000100000,
    ST_OUT   = 11'b00001000000,
    ST_MSQ2  = 11'b00010000000,
    ST_MSQ3  = 11'b00100000000,
    ST_VAR   = 11'b01000000000,
    ST_SIGM  = 11'b10000000000
  } state_e;
endpackage
`default_nettype wire

// ===== hdl/ao_if.sv =====
`default_nettype none
interface ao_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] open_price;
  logic [23:0] close_price;
  logic        series_start;
  modport source (output valid, open_price, close_price, series_start, input ready);
  modport sink (input valid, open_price, close_price, series_start, output ready);
endinterface

interface ao_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] bull_value;
  logic [23:0] bear_value;
  logic [23:0] signal_value;
  modport source (output valid, bull_value, bear_value, signal_value, input ready);
  modport sink (input valid, bull_value, bear_value, signal_value, output ready);
endinterface

interface ao_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ao_isqrt.sv =====
`default_nettype none
// Rounded integer square root, two radicand bits per cycle.
module ao_isqrt import ao_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [SW-1:0] value_i,
  output logic               done_o,
  output logic [PW-1:0]      root_o
);
  logic [SW+1:0] rem_q, rem_d;
  logic [SW+1:0] root_q, root_d;
  logic [SW-1:0] v_q, v_d;
  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [SW+1:0] trial;
  logic [SW+1:0] fin;

  always_comb begin
    rem_d = rem_q; root_d = root_q; v_d = v_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[SW-1:0], v_q[SW-1:SW-2]} - {root_q[SW-1:0], 2'b01};
    if (start_i) begin
      rem_d = '0; root_d = '0; v_d = value_i; cnt_d = 5'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step on the next radicand digit pair
      if (!trial[SW+1]) begin
        rem_d = trial;
        root_d = {root_q[SW:0], 1'b1};
      end else begin
        rem_d = {rem_q[SW-1:0], v_q[SW-1:SW-2]};
        root_d = {root_q[SW:0], 1'b0};
      end
      v_d = {v_q[SW-3:0], 2'b00};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(SW/2 - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  // round to nearest, saturate
  always_comb begin
    fin = (rem_q > root_q) ? root_q + 1'b1 : root_q;
    root_o = (fin > (SW+2)'((1 << PW) - 1)) ? '1 : fin[PW-1:0];
  end
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; root_q <= root_d; v_q <= v_d;
  end
endmodule
`default_nettype wire

// ===== hdl/andean_oscillator_core.sv =====
`default_nettype none
// Channel  | Dir | Payload
// in_if    | in  | open_price, close_price, series_start
// out_if   | out | bull_value, bear_value, signal_value
// cfg_if   | in  | index (0 alpha_main, 1 alpha_signal), data
// One shared 32x32 multiplier steps through the squares (2), the envelope
// scalings (high and low halves), the mean squares (hi*lo, hi*hi, lo*lo,
// run twice) and the signal scaling. The root unit runs 24 steps per
// envelope, then reports done. A series-start bar clears the envelopes and
// signal level and goes straight to the result load. The next bar is taken
// the cycle after a result is loaded, not before: one bar at a time.
// Reset clears envelopes, signal level and alphas to defaults. A stalled
// result holds in the output register while the next bar is computed; that
// bar waits in its last step until the register frees.
module andean_oscillator_core import ao_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ao_in_if.sink     in_if,
  ao_out_if.source  out_if,
  ao_cfg_if.sink    cfg_if
);
  state_e        st_q, st_d;
  logic [AW-1:0] am_q, as_q;
  logic [MW-1:0] um_q, lm_q, sl_q;
  logic [SW-1:0] us_q, ls_q;
  logic [PW-1:0] op_q, cl_q;
  logic [SW-1:0] ops_q, cls_q;
  logic [3:0]    k_q;
  logic [SW+16:0] acc_q;
  logic [PW-1:0] bull_q, bear_q, sig_q;
  logic [PW-1:0] res_bull_q, res_bear_q;
  logic          ov_q;
  logic          out_free;
  logic [SW-1:0] var_q;
  logic          rt_start;
  logic          rt_done;
  logic [PW-1:0] rt_root;
  logic          which_q;

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = ma * mb;

  function automatic logic [16:0] clampa(input logic [16:0] a);
    return a[16] ? 17'h10000 : a;
  endfunction

  function automatic logic [SW-1:0] mx3(input logic [SW-1:0] a, b, c, input logic big);
    logic [SW-1:0] m;
    if (big) begin m = (a > b) ? a : b; m = (m > c) ? m : c; end
    else begin m = (a < b) ? a : b; m = (m < c) ? m : c; end
    return m;
  endfunction

  // envelope operands for step k, or signal-level operands in the signal steps
  logic [SW-1:0] prev, tgt, dif;
  logic [16:0]   alph;
  always_comb begin
    unique case (k_q[1:0])
      2'd0: begin prev = SW'(um_q); tgt = SW'({cl_q, 8'h00}); end
      2'd1: begin prev = us_q; tgt = cls_q; end
      2'd2: begin prev = SW'(lm_q); tgt = SW'({cl_q, 8'h00}); end
      default: begin prev = ls_q; tgt = cls_q; end
    endcase
    if (st_q == ST_SIG || st_q == ST_SIGM) begin
      prev = SW'(sl_q);
      tgt = SW'({(bull_q > bear_q ? bull_q : bear_q), 8'h00});
      alph = clampa(as_q);
    end else alph = clampa(am_q);
    dif = (prev >= tgt) ? prev - tgt : tgt - prev;
  end

  logic [MW-1:0] msel;
  assign msel = which_q ? um_q : lm_q;

  always_comb begin
    ma = '0; mb = '0;
    unique case (st_q)
      ST_SQ:  begin ma = 32'(k_q[0] ? cl_q : op_q); mb = ma; end
      ST_ENV, ST_SIG: begin ma = dif[31:0]; mb = 32'(alph); end
      ST_SIGM, ST_MSQ: begin ma = 32'(dif[SW-1:32]); mb = 32'(alph); end
      ST_MSQ2: begin ma = 32'(msel[31:16]); mb = 32'(msel[15:0]); end
      ST_MSQ3: begin ma = 32'(msel[31:16]); mb = ma; end
      ST_VAR:  begin ma = 32'(msel[15:0]); mb = ma; end
      default: ;
    endcase
  end

  // result register frees when empty or taken this cycle
  assign out_free = !ov_q || out_if.ready;

  assign in_if.ready = (st_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = ov_q;
  assign out_if.bull_value = res_bull_q;
  assign out_if.bear_value = res_bear_q;
  assign out_if.signal_value = sig_q;

  logic [SW-1:0] step, nv, msq;
  logic [SW+16:0] sum;
  always_comb begin
    sum = acc_q + (SW+17)'(mp) + (SW+17)'(17'h8000);
    step = sum[SW+15:16];
    nv = (prev >= tgt) ? prev - step : prev + step;
    msq = acc_q[SW-1:0] + SW'((mp + 64'h8000) >> 16);
  end

  assign rt_start = (st_q == ST_VAR) && (k_q == 4'd3);
  ao_isqrt u_root (.clk_i, .rst_ni, .start_i(rt_start), .value_i(var_q),
                   .done_o(rt_done), .root_o(rt_root));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ov_q <= 1'b0; k_q <= '0; which_q <= 1'b0;
      am_q <= 17'd8738; as_q <= 17'd13107;
      um_q <= '0; lm_q <= '0; us_q <= '0; ls_q <= '0; sl_q <= '0;
    end else begin
      if (cfg_if.valid) begin
        if (cfg_if.index == CFG_ALPHA_MAIN) am_q <= cfg_if.data;
        else as_q <= cfg_if.data;
      end
      ov_q <= (st_q == ST_OUT) || (ov_q && !out_if.ready);
      unique case (st_q)
        ST_IDLE: if (in_if.valid && in_if.ready) begin
          op_q <= in_if.open_price; cl_q <= in_if.close_price; k_q <= '0;
          if (in_if.series_start) begin
            um_q <= '0; lm_q <= '0; us_q <= '0; ls_q <= '0; sl_q <= '0;
            bull_q <= '0; bear_q <= '0; st_q <= ST_OUT;
          end else st_q <= ST_SQ;
        end
        ST_SQ: begin
          if (k_q[0]) begin cls_q <= mp[SW-1:0]; k_q <= '0; st_q <= ST_MSQ; end
          else begin ops_q <= mp[SW-1:0]; k_q <= 4'd1; end
          acc_q <= '0;
        end
        // high partial product of the envelope scaling; after the last envelope, go to the mean square
        ST_MSQ: if (k_q[3]) begin
          acc_q <= '0; k_q <= '0; which_q <= 1'b0; st_q <= ST_MSQ2;
        end else begin
          acc_q <= {mp[32:0], 32'h0}; st_q <= ST_ENV;
        end
        ST_ENV: begin
          unique case (k_q[1:0])
            2'd0: um_q <= MW'(mx3(SW'({cl_q,8'h0}), SW'({op_q,8'h0}), nv, 1'b1));
            2'd1: us_q <= mx3(cls_q, ops_q, nv, 1'b1);
            2'd2: lm_q <= MW'(mx3(SW'({cl_q,8'h0}), SW'({op_q,8'h0}), nv, 1'b0));
            default: ls_q <= mx3(cls_q, ops_q, nv, 1'b0);
          endcase
          k_q <= (k_q == 4'd3) ? 4'd8 : k_q + 4'd1;
          st_q <= ST_MSQ;
        end
        // mean square: hi*lo twice, hi*hi, then lo*lo
        ST_MSQ2: begin acc_q <= (SW+17)'({mp, 1'b0}); st_q <= ST_MSQ3; end
        ST_MSQ3: begin acc_q <= acc_q + (SW+17)'({mp, 16'h0}); k_q <= 4'd0; st_q <= ST_VAR; end
        ST_VAR: if (k_q == 4'd0) begin
          var_q <= ((which_q ? us_q : ls_q) > msq) ? (which_q ? us_q : ls_q) - msq : '0;
          k_q <= 4'd3;
        end else begin k_q <= '0; st_q <= ST_ROOT; end
        ST_ROOT: if (rt_done) begin
          if (which_q) begin bear_q <= rt_root; st_q <= ST_SIGM; end
          else begin bull_q <= rt_root; which_q <= 1'b1; st_q <= ST_MSQ2; end
        end
        ST_SIGM: begin acc_q <= {mp[32:0], 32'h0}; st_q <= ST_SIG; end
        ST_SIG: begin
          sl_q <= nv[MW-1:0];
          st_q <= ST_OUT;
        end
        // load the result once the output register is free
        ST_OUT: if (out_free) begin
          res_bull_q <= bull_q;
          res_bear_q <= bear_q;
          sig_q <= (&sl_q[MW-1:8] && sl_q[7]) ? '1 : sl_q[MW-1:8] + 24'(sl_q[7]);
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
